// File: hdl/assert_macros.svh
// Assertion macros for the ellipse vertex generator RTL.
// Depends on nothing; included by evg_seq, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check, live through reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/evg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and table builders for the ellipse vertex generator.
// No dependencies; used by evg_seq, evg_datapath and the top level.
package evg_pkg;

  // Default configuration
  localparam int MAX_STEPS_PER_QUADRANT = 16;
  localparam int MIN_STEPS_PER_QUADRANT = 5;
  localparam int SINE_TABLE_BITS        = 8;
  localparam int FRACTION_BITS          = 4;

  // Upper ends of the configuration range, used to size shared fields
  localparam int STEPS_LIMIT      = 16;
  localparam int SINE_BITS_LIMIT  = 12;
  localparam int N_W              = $clog2(STEPS_LIMIT + 1);
  localparam int J_W              = $clog2(STEPS_LIMIT);
  localparam int PH_LIMIT_W       = SINE_BITS_LIMIT + 1;

  // Radius units subtracted to get the step count
  localparam int RADIUS_MARGIN = 3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Quadrant codes
  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

  // One vertex request from the sequencer to the datapath
  typedef struct packed {
    logic               vld;
    logic               last;
    quad_t              quad;
    logic [J_W-1:0]     j;
    logic [N_W-1:0]     n;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        rx;
    logic [14:0]        ry;
  } issue_t;

  // Quarter-wave sine entry, unsigned Q1.15, evaluated at elaboration
  function automatic logic [15:0] quarter_sine(input logic [63:0] p, input int tbits);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    u  = ((p << (16 - tbits)) * HALF_PI_Q30) >> 16;
    u2 = (u * u) >> 30;
    t  = ONE_Q30 - u2 / 72;
    t  = ONE_Q30 - (((u2 / 42) * t) >> 30);
    t  = ONE_Q30 - (((u2 / 20) * t) >> 30);
    t  = ONE_Q30 - (((u2 / 6) * t) >> 30);
    s  = (u * t) >> 30;
    r  = (s + (64'd1 << 14)) >> 15;
    return (r > 64'd32768) ? 16'd32768 : r[15:0];
  endfunction

  // Table phase of step j out of n, rounded half up, found by counting
  function automatic logic [PH_LIMIT_W-1:0] phase_of(input int n, input int j,
                                                     input int tbits);
    logic [63:0] full;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] p;
    full = 64'd1 << tbits;
    num  = 64'(j) * (full << 1) + 64'(n);
    den  = 64'(2 * n);
    p    = 64'd0;
    for (int k = 1; k <= (1 << tbits); k++) begin
      if (64'(k) * den <= num) begin
        p = 64'(k);
      end
    end
    return p[PH_LIMIT_W-1:0];
  endfunction

endpackage

// File: hdl/evg_seq.sv
`timescale 1ns / 1ps
// Vertex sequencer: latches one ellipse and issues its vertices one per cycle while en is high.
// Depends on evg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module evg_seq #(
  parameter int MAX_STEPS = evg_pkg::MAX_STEPS_PER_QUADRANT,
  parameter int MIN_STEPS = evg_pkg::MIN_STEPS_PER_QUADRANT,
  parameter int FRAC_BITS = evg_pkg::FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] ctr_x,
  input  logic signed [15:0] ctr_y,
  input  logic [14:0]        rad_x,
  input  logic [14:0]        rad_y,
  input  logic               reverse,
  output evg_pkg::issue_t    iss
);

  localparam int N_W = evg_pkg::N_W;
  localparam int J_W = evg_pkg::J_W;
  localparam logic [14:0] N_THRESH = 15'(MIN_STEPS + evg_pkg::RADIUS_MARGIN);

  logic                  busy_r, busy_nxt;
  logic                  rev_r, rev_nxt;
  evg_pkg::quad_t        quad_r, quad_nxt;
  logic [J_W-1:0]        j_r, j_nxt;
  logic [N_W-1:0]        n_r, n_nxt;
  logic signed [15:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic [14:0]           rx_r, rx_nxt, ry_r, ry_nxt;

  logic [14:0]    maxr;
  logic [14:0]    n_raw;
  logic [N_W-1:0] n_new;
  logic [J_W-1:0] j_top;
  logic           is_last;
  logic           accept;

  // Step count from the larger radius, floor then margin, min then cap
  always_comb begin
    maxr = ((rad_x > rad_y) ? rad_x : rad_y) >> FRAC_BITS;
    if (maxr >= N_THRESH) begin
      n_raw = maxr - 15'(evg_pkg::RADIUS_MARGIN);
    end else begin
      n_raw = 15'(MIN_STEPS);
    end
    if (n_raw > 15'(MAX_STEPS)) begin
      n_new = N_W'(MAX_STEPS);
    end else begin
      n_new = n_raw[N_W-1:0];
    end
  end

  // Final vertex: end of quadrant 3 going forward, start of quadrant 0 reversed
  assign j_top   = J_W'(n_r - N_W'(1));
  assign is_last = rev_r ? (quad_r == evg_pkg::QUAD_0 && j_r == '0)
                         : (quad_r == evg_pkg::QUAD_3 && j_r == j_top);
  assign in_ready = en && (!busy_r || is_last);
  assign accept   = in_valid && in_ready;

  // Advance the step counters, load a new ellipse on acceptance
  always_comb begin
    busy_nxt = busy_r;
    rev_nxt  = rev_r;
    quad_nxt = quad_r;
    j_nxt    = j_r;
    n_nxt    = n_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    if (en && busy_r) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else if (!rev_r) begin
        if (j_r == j_top) begin
          j_nxt    = '0;
          quad_nxt = quad_r + 2'd1;
        end else begin
          j_nxt = j_r + J_W'(1);
        end
      end else begin
        if (j_r == '0) begin
          j_nxt    = j_top;
          quad_nxt = quad_r - 2'd1;
        end else begin
          j_nxt = j_r - J_W'(1);
        end
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      rev_nxt  = reverse;
      n_nxt    = n_new;
      cx_nxt   = ctr_x;
      cy_nxt   = ctr_y;
      rx_nxt   = rad_x;
      ry_nxt   = rad_y;
      quad_nxt = reverse ? evg_pkg::QUAD_3 : evg_pkg::QUAD_0;
      j_nxt    = reverse ? J_W'(n_new - N_W'(1)) : '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Ellipse payload and counters
  always_ff @(posedge clk) begin
    rev_r  <= rev_nxt;
    quad_r <= quad_nxt;
    j_r    <= j_nxt;
    n_r    <= n_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
  end

  always_comb begin
    iss.vld  = busy_r;
    iss.last = is_last;
    iss.quad = quad_r;
    iss.j    = j_r;
    iss.n    = n_r;
    iss.cx   = cx_r;
    iss.cy   = cy_r;
    iss.rx   = rx_r;
    iss.ry   = ry_r;
  end

  `ASSERT_CLK_RST(a_step_in_range, clk, rst_n, busy_r |-> (N_W'(j_r) < n_r), "step index beyond step count")
  `ASSERT_CLK_RST(a_count_in_range, clk, rst_n, busy_r |-> (n_r <= N_W'(MAX_STEPS) && n_r != '0), "step count out of range")
  `ASSERT_CLK_RST(a_accept_on_last, clk, rst_n, (accept && busy_r) |-> (is_last && en), "new ellipse taken mid-sequence")
  `ASSERT_CLK(a_idle_after_reset, clk, !rst_n |=> !busy_r, "sequencer busy after reset")

endmodule

// File: hdl/evg_datapath.sv
`timescale 1ns / 1ps
// Vertex datapath: phase lookup, sine lookup, scaling multiply, round, add center and saturate.
// Depends on evg_pkg; fed by evg_seq.
module evg_datapath #(
  parameter int MAX_STEPS = evg_pkg::MAX_STEPS_PER_QUADRANT,
  parameter int SINE_BITS = evg_pkg::SINE_TABLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  evg_pkg::issue_t    iss,
  output logic               en,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] vertex_x,
  output logic signed [15:0] vertex_y,
  output logic               last
);

  localparam int FULL  = 1 << SINE_BITS;
  localparam int PH_W  = SINE_BITS + 1;
  localparam int IDX_W = $clog2(MAX_STEPS);
  localparam int N_W   = evg_pkg::N_W;

  // Constant tables
  logic [15:0]     sin_tab [0:FULL];
  logic [PH_W-1:0] ph_tab  [0:MAX_STEPS-1][0:MAX_STEPS-1];

  for (genvar g = 0; g <= FULL; g++) begin : g_sin
    assign sin_tab[g] = evg_pkg::quarter_sine(64'(g), SINE_BITS);
  end
  for (genvar gn = 0; gn < MAX_STEPS; gn++) begin : g_ph_n
    for (genvar gj = 0; gj < MAX_STEPS; gj++) begin : g_ph_j
      assign ph_tab[gn][gj] = PH_W'(evg_pkg::phase_of(gn + 1, gj, SINE_BITS));
    end
  end

  // Global advance: move when the output word is free or being taken
  logic v1_r, v2_r, v3_r, v4_r;
  assign en = out_ready || !v4_r;

  // Stage 1: phase of this step
  logic                  l1_r;
  evg_pkg::quad_t        q1_r;
  logic [PH_W-1:0]       ph1_r;
  logic signed [15:0]    cx1_r, cy1_r;
  logic [14:0]           rx1_r, ry1_r;
  logic [N_W-1:0]        nm1;

  assign nm1 = iss.n - N_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r  <= iss.last;
      q1_r  <= iss.quad;
      ph1_r <= ph_tab[nm1[IDX_W-1:0]][iss.j[IDX_W-1:0]];
      cx1_r <= iss.cx;
      cy1_r <= iss.cy;
      rx1_r <= iss.rx;
      ry1_r <= iss.ry;
    end
  end

  // Stage 2: sine and cosine magnitudes and signs by quadrant
  logic [15:0]        sa, sb;
  logic [15:0]        cm_nxt, sm_nxt;
  logic               cneg_nxt, sneg_nxt;
  logic               l2_r, cneg2_r, sneg2_r;
  logic [15:0]        cm2_r, sm2_r;
  logic signed [15:0] cx2_r, cy2_r;
  logic [14:0]        rx2_r, ry2_r;

  assign sa = sin_tab[ph1_r];
  assign sb = sin_tab[PH_W'(FULL) - ph1_r];

  always_comb begin
    case (q1_r)
      evg_pkg::QUAD_0: begin
        cm_nxt = sb; cneg_nxt = 1'b0; sm_nxt = sa; sneg_nxt = 1'b0;
      end
      evg_pkg::QUAD_1: begin
        cm_nxt = sa; cneg_nxt = 1'b1; sm_nxt = sb; sneg_nxt = 1'b0;
      end
      evg_pkg::QUAD_2: begin
        cm_nxt = sb; cneg_nxt = 1'b1; sm_nxt = sa; sneg_nxt = 1'b1;
      end
      default: begin
        cm_nxt = sa; cneg_nxt = 1'b0; sm_nxt = sb; sneg_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_r    <= l1_r;
      cm2_r   <= cm_nxt;
      sm2_r   <= sm_nxt;
      cneg2_r <= cneg_nxt;
      sneg2_r <= sneg_nxt;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      rx2_r   <= rx1_r;
      ry2_r   <= ry1_r;
    end
  end

  // Stage 3: scale by the radii
  logic               l3_r, cneg3_r, sneg3_r;
  logic [30:0]        mx3_r, my3_r;
  logic signed [15:0] cx3_r, cy3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l3_r    <= l2_r;
      cneg3_r <= cneg2_r;
      sneg3_r <= sneg2_r;
      mx3_r   <= 31'(rx2_r) * 31'(cm2_r);
      my3_r   <= 31'(ry2_r) * 31'(sm2_r);
      cx3_r   <= cx2_r;
      cy3_r   <= cy2_r;
    end
  end

  // Stage 4: round half away from zero, add center, saturate
  logic [31:0]        rnd_x, rnd_y;
  logic signed [17:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic               l4_r;
  logic signed [15:0] vx4_r, vy4_r;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  always_comb begin
    rnd_x = {1'b0, mx3_r} + 32'd16384;
    rnd_y = {1'b0, my3_r} + 32'd16384;
    sum_x = cneg3_r ? 18'(cx3_r) - $signed({2'b00, rnd_x[30:15]})
                    : 18'(cx3_r) + $signed({2'b00, rnd_x[30:15]});
    sum_y = sneg3_r ? 18'(cy3_r) - $signed({2'b00, rnd_y[30:15]})
                    : 18'(cy3_r) + $signed({2'b00, rnd_y[30:15]});
    sat_x = sat16(sum_x);
    sat_y = sat16(sum_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l4_r  <= l3_r;
      vx4_r <= sat_x;
      vy4_r <= sat_y;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= iss.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign vertex_x  = vx4_r;
  assign vertex_y  = vy4_r;
  assign last      = l4_r;

endmodule

// File: hdl/ellipse_vertex_generator.sv
`timescale 1ns / 1ps
// Ellipse vertex generator top level: stream ports, sequencer and datapath.
// An accepted ellipse word is registered in the sequencer, then passes the
// datapath stage registers before its first vertex word leaves the block.
// Throughput: one vertex per cycle while the output is not stalled; an ellipse has 4n vertices (20 to 64);
// the next ellipse is taken in the cycle its predecessor's last vertex issues.
// Reset: synchronous, active low; clears the sequencer and pipeline valids.
module ellipse_vertex_generator #(
  parameter int MAX_STEPS_PER_QUADRANT = evg_pkg::MAX_STEPS_PER_QUADRANT,
  parameter int MIN_STEPS_PER_QUADRANT = evg_pkg::MIN_STEPS_PER_QUADRANT,
  parameter int SINE_TABLE_BITS        = evg_pkg::SINE_TABLE_BITS,
  parameter int FRACTION_BITS          = evg_pkg::FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Ellipse words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // ctr_x[15:0], ctr_y[31:16], rad_x[46:32],
                                 // rad_y[61:47], zero pad[63:62]
  input  logic        in_tuser,  // reverse[0]
  // Vertex words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // vertex_x[15:0], vertex_y[31:16]
  output logic        out_tlast
);

  evg_pkg::issue_t    iss;
  logic               en;
  logic signed [15:0] vx, vy;

  evg_seq #(
    .MAX_STEPS (MAX_STEPS_PER_QUADRANT),
    .MIN_STEPS (MIN_STEPS_PER_QUADRANT),
    .FRAC_BITS (FRACTION_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .ctr_x    ($signed(in_tdata[15:0])),
    .ctr_y    ($signed(in_tdata[31:16])),
    .rad_x    (in_tdata[46:32]),
    .rad_y    (in_tdata[61:47]),
    .reverse  (in_tuser),
    .iss      (iss)
  );

  evg_datapath #(
    .MAX_STEPS (MAX_STEPS_PER_QUADRANT),
    .SINE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss       (iss),
    .en        (en),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .vertex_x  (vx),
    .vertex_y  (vy),
    .last      (out_tlast)
  );

  // Pack the vertex word
  assign out_tdata = {vy, vx};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ellipse_vertex_generator: drives ellipse words on the input stream
// and compares every vertex word against an outline predicted from the same word.
// Depends on evg_pkg and the RTL top level only.
module testbench;

  localparam int TAB_FULL   = 1 << evg_pkg::SINE_TABLE_BITS;
  localparam int IDLE_PCT   = 36;
  localparam int HOLD_START = 4000;
  localparam int HOLD_LEN   = 700;
  localparam int CALM_START = 15000;
  localparam int CALM_END   = 21000;
  localparam int N_RANDOM   = 412;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  // Predicted outline of each accepted ellipse, checked vertex by vertex
  class ellipse_outline;
    logic [15:0] sine_tab [0:TAB_FULL];
    vertex_t     pending_vertices [$];
    int          mismatches;
    int          vertex_count;

    function new();
      for (int p = 0; p <= TAB_FULL; p++) sine_tab[p] = sine_at(p);
      mismatches   = 0;
      vertex_count = 0;
    endfunction

    // Quarter-wave sine in Q1.15 from a truncated Q2.30 Taylor series
    function logic [15:0] sine_at(int p);
      logic [63:0] ang;
      logic [63:0] sq;
      logic [63:0] poly;
      logic [63:0] s;
      logic [63:0] r;
      int          divs [4];
      divs = '{72, 42, 20, 6};
      ang  = ((64'(p) << (16 - evg_pkg::SINE_TABLE_BITS)) * evg_pkg::HALF_PI_Q30) >> 16;
      sq   = (ang * ang) >> 30;
      poly = evg_pkg::ONE_Q30;
      foreach (divs[k])
        poly = evg_pkg::ONE_Q30 - (((sq / 64'(divs[k])) * poly) >> 30);
      s = (ang * poly) >> 30;
      r = (s + (64'd1 << 14)) >> 15;
      return (r > 64'd32768) ? 16'd32768 : r[15:0];
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Radius times trig magnitude, halves rounded away from zero
    function longint scaled(logic [14:0] radius, logic [15:0] mag, logic neg);
      longint m;
      m = (longint'(radius) * longint'(mag) + (longint'(1) << 14)) >> 15;
      return neg ? -m : m;
    endfunction

    // Expand one ellipse word into its vertex sequence
    function void note_ellipse(logic [63:0] word, logic rev);
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [14:0]        rx;
      logic [14:0]        ry;
      int                 maxr;
      int                 n;
      int                 total;
      int                 idx;
      int                 j;
      int                 ph;
      evg_pkg::quad_t     qd;
      logic [15:0]        sa;
      logic [15:0]        sb;
      logic [15:0]        cmag;
      logic [15:0]        smag;
      logic               cneg;
      logic               sneg;
      vertex_t            v;
      cx    = word[15:0];
      cy    = word[31:16];
      rx    = word[46:32];
      ry    = word[61:47];
      maxr  = int'((rx > ry) ? rx : ry) >> evg_pkg::FRACTION_BITS;
      n     = (maxr >= evg_pkg::MIN_STEPS_PER_QUADRANT + evg_pkg::RADIUS_MARGIN)
              ? maxr - evg_pkg::RADIUS_MARGIN : evg_pkg::MIN_STEPS_PER_QUADRANT;
      if (n > evg_pkg::MAX_STEPS_PER_QUADRANT) n = evg_pkg::MAX_STEPS_PER_QUADRANT;
      total = 4 * n;
      for (int k = 0; k < total; k++) begin
        idx = rev ? total - 1 - k : k;
        qd  = evg_pkg::quad_t'(idx / n);
        j   = idx % n;
        ph  = (j * (2 * TAB_FULL) + n) / (2 * n);
        sa  = sine_tab[ph];
        sb  = sine_tab[TAB_FULL - ph];
        case (qd)
          evg_pkg::QUAD_0: begin
            cmag = sb; cneg = 1'b0; smag = sa; sneg = 1'b0;
          end
          evg_pkg::QUAD_1: begin
            cmag = sa; cneg = 1'b1; smag = sb; sneg = 1'b0;
          end
          evg_pkg::QUAD_2: begin
            cmag = sb; cneg = 1'b1; smag = sa; sneg = 1'b1;
          end
          default: begin
            cmag = sa; cneg = 1'b0; smag = sb; sneg = 1'b1;
          end
        endcase
        v.x    = clamp16(longint'(cx) + scaled(rx, cmag, cneg));
        v.y    = clamp16(longint'(cy) + scaled(ry, smag, sneg));
        v.last = (k == total - 1);
        pending_vertices.push_back(v);
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at vertex %0d: %s got %0d expected %0d",
               vertex_count, what, got, want);
    endtask

    // Compare one vertex word with the oldest predicted vertex
    task match_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected vertex, x", x, 0);
      end else begin
        want = pending_vertices.pop_front();
        if (x !== want.x) report_mismatch("vertex_x", x, want.x);
        if (y !== want.y) report_mismatch("vertex_y", y, want.y);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
      vertex_count++;
    endtask

    function int pending();
      return pending_vertices.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // ctr_x[15:0], ctr_y[31:16], rad_x[46:32],
                           // rad_y[61:47], zero pad[63:62]
  logic        in_tuser;   // reverse[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // vertex_x[15:0], vertex_y[31:16]
  logic        out_tlast;
  int unsigned rx_cycle = 0;

  ellipse_outline outline = new();

  ellipse_vertex_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, one long hold-off, one calm window
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
      out_tready <= 1'b0;
    end else if (rx_cycle >= CALM_START && rx_cycle < CALM_END) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Note accepted ellipse words first, then check the vertex word of this edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) outline.note_ellipse(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready)
      outline.match_vertex(out_tdata[15:0], out_tdata[31:16], out_tlast);
  end

  // Offer one ellipse word after a random gap and hold it until taken
  task automatic offer_ellipse(input logic [15:0] cx, input logic [15:0] cy,
                               input logic [14:0] rx, input logic [14:0] ry,
                               input logic rev, input int gap_pct);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, ry, rx, cy, cx};
    in_tuser  <= rev;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly radii that sweep the step count, sometimes any 15-bit value
  function automatic logic [14:0] pick_radius();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 15'($urandom_range(0, 26 * 16));
    if (sel < 9) return 15'($urandom);
    return 15'($urandom_range(7 * 16, 21 * 16 - 1));
  endfunction

  // Mostly any center, sometimes near either end to force saturation
  function automatic logic [15:0] pick_center();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom);
    if (sel < 9) return 16'(32767 - $urandom_range(0, 600));
    return 16'(-32768 + $urandom_range(0, 600));
  endfunction

  initial begin
    int gap;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero radii, step-count thresholds, cap, saturation, bit patterns
    offer_ellipse(16'd0, 16'd0, 15'd0, 15'd0, 1'b0, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'd0, 15'd0, 1'b1, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'd127, 15'd0, 1'b0, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'd128, 15'd0, 1'b1, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'd0, 15'd144, 1'b0, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'd200, 15'd16, 1'b0, IDLE_PCT);
    offer_ellipse(16'd100, -16'sd100, 15'd304, 15'd200, 1'b0, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'd320, 15'd320, 1'b1, IDLE_PCT);
    offer_ellipse(16'd0, 16'd0, 15'h7fff, 15'h7fff, 1'b0, IDLE_PCT);
    offer_ellipse(16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 1'b0, IDLE_PCT);
    offer_ellipse(16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 1'b1, IDLE_PCT);
    offer_ellipse(16'h7fff, 16'h8000, 15'h7fff, 15'd0, 1'b0, IDLE_PCT);
    offer_ellipse(16'h8000, 16'h7fff, 15'd0, 15'h7fff, 1'b1, IDLE_PCT);
    offer_ellipse(16'h5555, 16'haaaa, 15'h2aaa, 15'h5555, 1'b1, IDLE_PCT);
    offer_ellipse(16'haaaa, 16'h5555, 15'h5555, 15'h2aaa, 1'b0, IDLE_PCT);
    offer_ellipse(16'hffff, 16'd1, 15'd1, 15'd1, 1'b0, IDLE_PCT);
    offer_ellipse(16'd12345, -16'sd12345, 15'd4000, 15'd250, 1'b1, IDLE_PCT);
    offer_ellipse(16'hffff, 16'hffff, 15'h7fff, 15'h7fff, 1'b1, 0);
    offer_ellipse(16'd0, 16'd0, 15'd0, 15'd0, 1'b1, 0);

    // Random ellipses, with a stretch of back-to-back words in the middle
    for (int k = 0; k < N_RANDOM; k++) begin
      gap = (k >= 200 && k < 270) ? 0 : IDLE_PCT;
      offer_ellipse(pick_center(), pick_center(), pick_radius(), pick_radius(),
                    1'($urandom), gap);
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding vertices, then let the pipeline settle
    while (outline.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (outline.mismatches == 0 && outline.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
